>>> design/brfc_pkg.sv
// ----------------------------------------------------------------------------
// brfc_pkg
// Shared types and constants for the response frame checker: verdict codes,
// register indexes, reset values and the per-frame verdict function.
// ----------------------------------------------------------------------------
package brfc_pkg;

    // Default receive buffer size in bytes (legal range 8 to 127, the most that the 7-bit frame length holds).
    localparam int BUFFER_BYTES_DEF = 64;

    // Configuration register indexes and widths.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXPECTED_COMMAND = 2'd0,
        REG_START_MARKER     = 2'd1,
        REG_STOP_MARKER      = 2'd2
    } t_cfg_reg;

    localparam logic [7:0] EXPECTED_COMMAND_RST = 8'd3;
    localparam logic [7:0] START_MARKER_RST     = 8'd221;
    localparam logic [7:0] STOP_MARKER_RST      = 8'd119;

    // Count width wide enough for any legal buffer size.
    localparam int CNT_W_MAX = 9;
    localparam int LEN_W     = 7;
    localparam int SUM_W     = 16;

    localparam logic [CNT_W_MAX-1:0] MIN_FRAME_BYTES = 9'd4;

    typedef enum logic [2:0] {
        VERDICT_OK          = 3'd0,
        VERDICT_EMPTY       = 3'd1,
        VERDICT_HEADER_BAD  = 3'd2,
        VERDICT_TOO_SHORT   = 3'd3,
        VERDICT_CHECKSUM_BAD = 3'd4
    } t_verdict;

    // One finished frame as it goes to the result register.
    typedef struct packed {
        t_verdict          verdict;
        logic [LEN_W-1:0]  frame_length;
        logic [SUM_W-1:0]  computed_sum;
    } t_result;

    // Two's complement of the running sum, as the sender computes it.
    function automatic logic [SUM_W-1:0] checksum_of(input logic [SUM_W-1:0] sum);
        return SUM_W'(0) - sum;
    endfunction

    // Verdict precedence: empty, header, too short, checksum.
    function automatic t_verdict verdict_of(
        input logic [CNT_W_MAX-1:0] count,
        input logic                 header_good,
        input logic [SUM_W-1:0]     sum,
        input logic [7:0]           older_byte,
        input logic [7:0]           newest_byte
    );
        t_verdict v;
        if (count == '0) begin
            v = VERDICT_EMPTY;
        end else if (!header_good) begin
            v = VERDICT_HEADER_BAD;
        end else if (count < MIN_FRAME_BYTES) begin
            v = VERDICT_TOO_SHORT;
        end else if (checksum_of(sum) != {older_byte, newest_byte}) begin
            v = VERDICT_CHECKSUM_BAD;
        end else begin
            v = VERDICT_OK;
        end
        return v;
    endfunction

endpackage

>>> design/bms_response_frame_checker.sv
// ----------------------------------------------------------------------------
// bms_response_frame_checker
// Collects received bytes into response frames, checks start byte, command
// echo, zero status byte and the trailing checksum, and reports one verdict
// per frame.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                Payload
//  input     in         i_in_valid / o_in_stall  i_rx_byte, i_timed_out
//  result    out        o_out_valid / i_out_stall o_verdict, o_frame_length,
//                                                 o_computed_sum
//  config    in         i_cfg_we                 i_cfg_index, i_cfg_data
//
// One byte request is taken per cycle while o_in_stall is low; its frame
// state updates at once and a frame end puts the result in the output
// register, or in the skid register if that is still full, on the same edge.
// A skid register behind the output register absorbs one result while the
// result side stalls; o_in_stall is simply that skid register being full.
// Reset (synchronous, active low) clears the frame state, the result valids
// and restores the register reset values.
// ----------------------------------------------------------------------------
module bms_response_frame_checker
    import brfc_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_timed_out,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [2:0]            o_verdict,
    output logic [LEN_W-1:0]      o_frame_length,
    output logic [SUM_W-1:0]      o_computed_sum,

    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(BUFFER_BYTES);

    // Configuration registers.
    logic [7:0] r_expected_command;
    logic [7:0] r_start_marker;
    logic [7:0] r_stop_marker;

    // Frame state.
    logic [CNT_W-1:0] r_count,  n_count;
    logic             r_header_good, n_header_good;
    logic [SUM_W-1:0] r_sum,    n_sum;
    logic [7:0]       r_older,  n_older;
    logic [7:0]       r_newest, n_newest;

    // Result register and skid register.
    logic    r_out_valid,  n_out_valid;
    t_result r_out,        n_out;
    logic    r_skid_valid, n_skid_valid;
    t_result r_skid,       n_skid;

    logic                 in_accept;
    logic                 out_taken;
    logic                 frame_end;
    logic                 result_valid;
    t_result              result;
    logic [CNT_W-1:0]     end_count;
    logic                 end_header;
    logic [SUM_W-1:0]     end_sum;
    logic [7:0]           end_older;
    logic [7:0]           end_newest;
    logic [CNT_W+CNT_W_MAX-1:0] count_wide;
    logic [CNT_W+LEN_W-1:0]     len_wide;
    logic                 upd_header;
    logic [SUM_W-1:0]     upd_sum;
    logic [CNT_W-1:0]     upd_count;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_taken = r_out_valid && !i_out_stall;
    assign frame_end = i_timed_out || (i_rx_byte == r_stop_marker);

    // Byte update as if the byte is stored.
    always_comb begin
        upd_header = r_header_good;
        if (r_count == CNT_W'(0) && i_rx_byte != r_start_marker) begin
            upd_header = 1'b0;
        end else if (r_count == CNT_W'(1) && i_rx_byte != r_expected_command) begin
            upd_header = 1'b0;
        end else if (r_count == CNT_W'(2) && i_rx_byte != 8'h00) begin
            upd_header = 1'b0;
        end
        // The byte sliding out of the two-byte window belongs to the summed range.
        upd_sum   = (r_count >= CNT_W'(4)) ? r_sum + SUM_W'(r_older) : r_sum;
        upd_count = r_count + CNT_W'(1);
    end

    always_comb begin
        n_count       = r_count;
        n_header_good = r_header_good;
        n_sum         = r_sum;
        n_older       = r_older;
        n_newest      = r_newest;
        result_valid  = 1'b0;
        end_count     = r_count;
        end_header    = r_header_good;
        end_sum       = r_sum;
        end_older     = r_older;
        end_newest    = r_newest;

        if (in_accept) begin
            if (frame_end) begin
                result_valid = 1'b1;
            end else begin
                end_count  = upd_count;
                end_header = upd_header;
                end_sum    = upd_sum;
                end_older  = r_newest;
                end_newest = i_rx_byte;
                result_valid = (upd_count == FULL_COUNT);
            end

            if (result_valid) begin
                n_count       = '0;
                n_header_good = 1'b1;
                n_sum         = '0;
                n_older       = '0;
                n_newest      = '0;
            end else begin
                n_count       = upd_count;
                n_header_good = upd_header;
                n_sum         = upd_sum;
                n_older       = r_newest;
                n_newest      = i_rx_byte;
            end
        end

        count_wide          = {{CNT_W_MAX{1'b0}}, end_count};
        len_wide            = {{LEN_W{1'b0}}, end_count};
        result.verdict      = verdict_of(count_wide[CNT_W_MAX-1:0], end_header, end_sum,
                                         end_older, end_newest);
        result.frame_length = len_wide[LEN_W-1:0];
        // Four bytes or fewer leave the sum at zero, so the checksum is zero.
        result.computed_sum = checksum_of(end_sum);
    end

    // Output register with skid stage.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;

        if (out_taken) begin
            n_out_valid = 1'b0;
        end
        if (!n_out_valid && r_skid_valid) begin
            n_out_valid  = 1'b1;
            n_out        = r_skid;
            n_skid_valid = 1'b0;
        end
        if (result_valid) begin
            if (!n_out_valid) begin
                n_out_valid = 1'b1;
                n_out       = result;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_command <= EXPECTED_COMMAND_RST;
            r_start_marker     <= START_MARKER_RST;
            r_stop_marker      <= STOP_MARKER_RST;
            r_count            <= '0;
            r_header_good      <= 1'b1;
            r_sum              <= '0;
            r_older            <= '0;
            r_newest           <= '0;
            r_out_valid        <= 1'b0;
            r_skid_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_EXPECTED_COMMAND: r_expected_command <= i_cfg_data;
                    REG_START_MARKER:     r_start_marker     <= i_cfg_data;
                    REG_STOP_MARKER:      r_stop_marker      <= i_cfg_data;
                    default: ;
                endcase
            end
            r_count       <= n_count;
            r_header_good <= n_header_good;
            r_sum         <= n_sum;
            r_older       <= n_older;
            r_newest      <= n_newest;
            r_out_valid   <= n_out_valid;
            r_skid_valid  <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_in_stall     = r_skid_valid;
    assign o_out_valid    = r_out_valid;
    assign o_verdict      = r_out.verdict;
    assign o_frame_length = r_out.frame_length;
    assign o_computed_sum = r_out.computed_sum;

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for bms_response_frame_checker. A clocked driver sends
// byte requests from a queue and a clocked monitor takes verdicts. Each
// accepted byte goes through a frame model in the bench, and each verdict is
// compared field by field with the oldest prediction. The run is a short
// directed part, then random frames under several register settings and
// idle patterns, one phase holding the result side off for a long stretch.
// ----------------------------------------------------------------------------
module tb_top
    import brfc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUF_BYTES      = BUFFER_BYTES_DEF;
    localparam int PHASE_ITEMS    = 290;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct {
        logic [7:0] rx;
        logic       tmo;
    } t_rx_req;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [7:0]            i_rx_byte = '0;
    logic                  i_timed_out = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [2:0]            o_verdict;
    logic [LEN_W-1:0]      o_frame_length;
    logic [SUM_W-1:0]      o_computed_sum;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Register copies used by the frame model and the frame generator.
    logic [7:0] cfg_cmd   = EXPECTED_COMMAND_RST;
    logic [7:0] cfg_start = START_MARKER_RST;
    logic [7:0] cfg_stop  = STOP_MARKER_RST;

    // Frame model state.
    int          frame_cnt = 0;
    logic        hdr_ok = 1'b1;
    logic [15:0] sum_acc = '0;
    logic [7:0]  tail_bytes [2] = '{8'h00, 8'h00};

    t_rx_req pending_bytes[$];
    t_result pending_verdicts[$];
    int      queued = 0;
    int      errors = 0;
    int      send_idle_pct = 0;
    int      stall_pct = 0;
    bit      hold_req = 1'b0;
    int      idle_cycles = 0;

    bms_response_frame_checker #(.BUFFER_BYTES(BUF_BYTES)) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .i_timed_out    (i_timed_out),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_verdict      (o_verdict),
        .o_frame_length (o_frame_length),
        .o_computed_sum (o_computed_sum),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Closes the current frame: grades it, queues the verdict and clears.
    function automatic void close_frame();
        t_result r;
        r.computed_sum = 16'h0000 - sum_acc;
        r.frame_length = LEN_W'(frame_cnt);
        if (frame_cnt == 0) begin
            r.verdict = VERDICT_EMPTY;
        end else if (!hdr_ok) begin
            r.verdict = VERDICT_HEADER_BAD;
        end else if (frame_cnt < 4) begin
            r.verdict = VERDICT_TOO_SHORT;
        end else if (r.computed_sum != {tail_bytes[0], tail_bytes[1]}) begin
            r.verdict = VERDICT_CHECKSUM_BAD;
        end else begin
            r.verdict = VERDICT_OK;
        end
        pending_verdicts.push_back(r);
        frame_cnt = 0;
        hdr_ok = 1'b1;
        sum_acc = '0;
        tail_bytes[0] = 8'h00;
        tail_bytes[1] = 8'h00;
    endfunction

    function automatic void take_byte(input logic [7:0] rx, input logic tmo);
        if (tmo || rx == cfg_stop) begin
            close_frame();
            return;
        end
        if ((frame_cnt == 0 && rx != cfg_start) || (frame_cnt == 1 && rx != cfg_cmd) ||
            (frame_cnt == 2 && rx != 8'h00)) begin
            hdr_ok = 1'b0;
        end
        // The byte that leaves the two-byte window is part of the summed range.
        if (frame_cnt >= 4) begin
            sum_acc = sum_acc + 16'(tail_bytes[0]);
        end
        tail_bytes[0] = tail_bytes[1];
        tail_bytes[1] = rx;
        frame_cnt++;
        if (frame_cnt >= BUF_BYTES) begin
            close_frame();
        end
    endfunction

    always @(posedge i_clk) begin : drive
        t_rx_req req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                take_byte(i_rx_byte, i_timed_out);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    req = pending_bytes.pop_front();
                    i_in_valid  <= 1'b1;
                    i_rx_byte   <= req.rx;
                    i_timed_out <= req.tmo;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report(input string field, input int exp_val, input int act_val);
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, exp_val, act_val);
        errors++;
    endtask

    always @(posedge i_clk) begin : watch
        t_result exp_r;
        int hold_left;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_verdicts.size() == 0) begin
                    $display("%0t: verdict with no frame pending: expected none, actual %0d/%0d/%0d",
                             $time, o_verdict, o_frame_length, o_computed_sum);
                    errors++;
                end else begin
                    exp_r = pending_verdicts.pop_front();
                    if (o_verdict != exp_r.verdict)
                        report("verdict", exp_r.verdict, o_verdict);
                    if (o_frame_length != exp_r.frame_length)
                        report("frame_length", exp_r.frame_length, o_frame_length);
                    if (o_computed_sum != exp_r.computed_sum)
                        report("computed_sum", exp_r.computed_sum, o_computed_sum);
                end
            end
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d verdicts outstanding", $time,
                     pending_verdicts.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic push_req(input logic [7:0] rx, input logic tmo);
        t_rx_req req;
        req.rx = rx;
        req.tmo = tmo;
        pending_bytes.push_back(req);
        queued++;
    endtask

    function automatic logic [7:0] rand_payload();
        logic [7:0] v;
        do begin
            v = 8'($urandom_range(0, 255));
        end while (v == cfg_stop);
        return v;
    endfunction

    task automatic gen_frame();
        logic [7:0] fr[$];
        logic [15:0] acc;
        int kind;
        int n;
        int j;
        bit noise;
        kind = $urandom_range(0, 99);
        noise = 1'b0;
        if (kind < 75) begin
            // Well-formed frame; some fill the buffer, some get one byte corrupted.
            if (kind >= 60 && kind < 66) begin
                n = BUF_BYTES;
            end else if ($urandom_range(0, 9) == 0) begin
                n = $urandom_range(5, BUF_BYTES - 1);
            end else begin
                n = $urandom_range(5, 12);
            end
            fr.push_back(cfg_start);
            fr.push_back(cfg_cmd);
            fr.push_back(8'h00);
            while (fr.size() < n - 2) fr.push_back(rand_payload());
            acc = '0;
            for (j = 2; j < n - 2; j++) acc = acc + 16'(fr[j]);
            acc = 16'h0000 - acc;
            fr.push_back(acc[15:8]);
            fr.push_back(acc[7:0]);
            if (kind >= 66) begin
                j = $urandom_range(0, n - 1);
                fr[j] = fr[j] ^ 8'($urandom_range(1, 255));
            end
        end else if (kind < 87) begin
            n = $urandom_range(1, 3);
            fr.push_back(cfg_start);
            if (n > 1) fr.push_back(cfg_cmd);
            if (n > 2) fr.push_back(8'h00);
            if ($urandom_range(0, 3) == 0) fr[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
        end else begin
            noise = 1'b1;
            n = $urandom_range(0, 8);
            repeat (n) fr.push_back(8'($urandom_range(0, 255)));
        end
        foreach (fr[i]) push_req(fr[i], noise && $urandom_range(0, 9) == 0);
        if (fr.size() != BUF_BYTES && !(noise && $urandom_range(0, 1) == 0)) begin
            if ($urandom_range(0, 3) == 0) begin
                push_req(8'($urandom_range(0, 255)), 1'b1);
            end else begin
                push_req(cfg_stop, 1'b0);
            end
        end
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [7:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        case (idx)
            REG_EXPECTED_COMMAND: cfg_cmd = v;
            REG_START_MARKER:     cfg_start = v;
            REG_STOP_MARKER:      cfg_stop = v;
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [7:0] cmd, input logic [7:0] start, input logic [7:0] stop);
        write_reg(REG_EXPECTED_COMMAND, cmd);
        write_reg(REG_START_MARKER, start);
        write_reg(REG_STOP_MARKER, stop);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Waits until every queued request is taken and every verdict is back.
    task automatic drain();
        @(negedge i_clk);
        while (pending_bytes.size() != 0 || i_in_valid || pending_verdicts.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int p;
        int phase_start;
        logic [7:0] rs;
        logic [7:0] rp;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty frames, by stop marker and by timeout with the byte ignored.
        push_req(cfg_stop, 1'b0);
        push_req(8'hFF, 1'b1);
        // Short frames: good start only, bad start, bad command echo.
        push_req(cfg_start, 1'b0);
        push_req(cfg_stop, 1'b0);
        push_req(8'h00, 1'b0);
        push_req(cfg_stop, 1'b0);
        push_req(cfg_start, 1'b0);
        push_req(cfg_cmd + 8'd1, 1'b0);
        push_req(cfg_stop, 1'b0);
        // Full header, then timeout carrying the stop value.
        push_req(cfg_start, 1'b0);
        push_req(cfg_cmd, 1'b0);
        push_req(8'h00, 1'b0);
        push_req(cfg_stop, 1'b1);
        // Shortest good frame: the checksum covers no byte and must read zero.
        push_req(cfg_start, 1'b0);
        push_req(cfg_cmd, 1'b0);
        push_req(8'h00, 1'b0);
        push_req(8'h00, 1'b0);
        push_req(cfg_stop, 1'b0);
        // Same length with a wrong checksum.
        push_req(cfg_start, 1'b0);
        push_req(cfg_cmd, 1'b0);
        push_req(8'h00, 1'b0);
        push_req(8'h01, 1'b0);
        push_req(8'h00, 1'b1);
        // Nonzero status byte.
        push_req(cfg_start, 1'b0);
        push_req(cfg_cmd, 1'b0);
        push_req(8'hFF, 1'b0);
        push_req(cfg_stop, 1'b0);
        drain();

        for (p = 0; p < 6; p++) begin
            rs = 8'($urandom_range(0, 255));
            do begin
                rp = 8'($urandom_range(0, 255));
            end while (rp == rs);
            case (p)
                0: set_regs(8'h00, 8'h00, 8'hFF);
                1: set_regs(8'hFF, 8'hFF, 8'h00);
                3: set_regs(EXPECTED_COMMAND_RST, START_MARKER_RST, STOP_MARKER_RST);
                default: set_regs(8'($urandom_range(0, 255)), rs, rp);
            endcase
            case (p)
                1: begin send_idle_pct = 63; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 63; end
                3, 5: begin send_idle_pct = 31; stall_pct = 31; end
                default: begin send_idle_pct = 0; stall_pct = 0; end
            endcase
            phase_start = queued;
            while (queued - phase_start < PHASE_ITEMS) gen_frame();
            // Result side holds off while the sender keeps offering bytes.
            if (p == 4) hold_req = 1'b1;
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (errors == 0 && pending_verdicts.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
